/* hw/rtl/chlg_pkg.sv */
// shared types, codes and constants of the hotplug load governor
package chlg_pkg;

    localparam int RING_DEPTH_DEF = 32;

    localparam int TASK_W   = 8;
    localparam int CORES_W  = 3;
    localparam int LOAD_W   = 15;
    localparam int ACTION_W = 3;
    localparam int DELAY_W  = 11;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam logic [6:0]         LOAD_SCALE = 7'd100;
    localparam logic [DELAY_W-1:0] DELAY_MAX  = 11'd2047;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALL_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DISABLE  = 3'd6;

    // register reset values
    localparam logic [9:0] RST_ALL_THR  = 10'd500;
    localparam logic [8:0] RST_UP_THR   = 9'd225;
    localparam logic [7:0] RST_DOWN_THR = 8'd100;
    localparam logic [2:0] RST_LIMIT    = 3'd4;
    localparam logic [5:0] RST_WINDOW   = 6'd18;
    localparam logic [8:0] RST_INTERVAL = 9'd20;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_NONE       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ONLINE_ALL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ONLINE_ONE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_OFFLINE    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_HELD       = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_DIV,
        ST_DECIDE,
        ST_FIN
    } t_state;

endpackage

/* hw/rtl/cpu_hotplug_load_governor.sv */
// top level of the moving-average core hotplug governor
// usage
//  - slave stream: one transfer per item; tuser is the command (0 load sample,
//    1 clear pause), tdata carries task count, cores online and offline pending
//  - master stream: one transfer per item with action, average load, next delay
//    and the pause flag after the item
//  - config port: write enable, register index, data; write only while idle
// timing
//  - a sample passes ST_WRITE, a walk of W ring entries in ST_READ, ST_DRAIN,
//    the divide of the S-bit sum in ST_DIV, ST_DECIDE and ST_FIN; W the clamped
//    window, S the sum width (LOAD_W + clog2(RING_DEPTH)); the ring walk reads
//    one entry a cycle and the divider gives one quotient bit a cycle
//  - an unpause item goes from idle straight to ST_FIN
//  - s_axis_tready is high only while idle, so no new item until the last is through
// reset
//  - registers to their defaults, pause flag set, ring empty; a fill count
//    makes never-written ring entries read as zero, so no clearing pass
// stall
//  - the result sits in an output register; the next item is accepted while it
//    waits, and that item's result is held back until the register frees
module cpu_hotplug_load_governor #(
    parameter int RING_DEPTH = chlg_pkg::RING_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] runnable_tasks, [10:8] cores_online, [11] offline_pending, rest zero
    input  logic [chlg_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] command
    input  logic                           s_axis_tuser,
    // master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [2:0] action, [17:3] average_load, [28:18] next_delay_ms, [29] paused_now
    output logic [chlg_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [chlg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [chlg_pkg::CFG_W-1:0]     i_cfg_wdata
);

    import chlg_pkg::*;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int WIN_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = LOAD_W + $clog2(RING_DEPTH);
    localparam int DCNT_W = $clog2(SUM_W + 1);

    // configuration registers
    logic [9:0] r_cfg_all;
    logic [8:0] r_cfg_up;
    logic [7:0] r_cfg_down;
    logic [2:0] r_cfg_limit;
    logic [5:0] r_cfg_window;
    logic [8:0] r_cfg_interval;
    logic       r_cfg_disabled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_all      <= RST_ALL_THR;
            r_cfg_up       <= RST_UP_THR;
            r_cfg_down     <= RST_DOWN_THR;
            r_cfg_limit    <= RST_LIMIT;
            r_cfg_window   <= RST_WINDOW;
            r_cfg_interval <= RST_INTERVAL;
            r_cfg_disabled <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ALL_THR:  r_cfg_all      <= i_cfg_wdata[9:0];
                REG_UP_THR:   r_cfg_up       <= i_cfg_wdata[8:0];
                REG_DOWN_THR: r_cfg_down     <= i_cfg_wdata[7:0];
                REG_LIMIT:    r_cfg_limit    <= i_cfg_wdata[2:0];
                REG_WINDOW:   r_cfg_window   <= i_cfg_wdata[5:0];
                REG_INTERVAL: r_cfg_interval <= i_cfg_wdata[8:0];
                REG_DISABLE:  r_cfg_disabled <= i_cfg_wdata[0];
                default: ;  // index beyond the list is ignored
            endcase
        end
    end

    // sequencer and datapath registers
    t_state r_state, n_state;

    logic [TASK_W-1:0]   r_tasks;
    logic [CORES_W-1:0]  r_online;
    logic                r_pending;
    logic                r_paused;
    logic [ADDR_W-1:0]   r_pos;       // next ring write slot
    logic [FILL_W-1:0]   r_fill;      // entries written since reset
    logic [ADDR_W-1:0]   r_rd_addr;   // backward walk pointer
    logic [WIN_W-1:0]    r_win;       // clamped window
    logic [WIN_W-1:0]    r_cnt;       // reads issued
    logic                r_acc;       // read data arrives this cycle
    logic                r_hit;       // that entry was written
    logic [SUM_W-1:0]    r_sum;       // sum, then quotient
    logic [WIN_W-1:0]    r_rem;
    logic [DCNT_W-1:0]   r_div_cnt;

    logic [ACTION_W-1:0] r_res_action;
    logic [LOAD_W-1:0]   r_res_avg;
    logic [DELAY_W-1:0]  r_res_delay;
    logic                r_res_paused;

    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    // control strobes
    logic c_in_ready;
    logic c_ram_we;
    logic c_ram_re;
    logic c_out_load;

    logic in_xfer;
    logic out_free;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = s_axis_tuser ? ST_FIN : ST_WRITE;
                end
            end
            ST_WRITE:  n_state = ST_READ;
            ST_READ: begin
                if (r_cnt == r_win - WIN_W'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_div_cnt == DCNT_W'(1)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        c_in_ready = 1'b0;
        c_ram_we   = 1'b0;
        c_ram_re   = 1'b0;
        c_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE:  c_in_ready = 1'b1;
            ST_WRITE: c_ram_we   = 1'b1;
            ST_READ:  c_ram_re   = 1'b1;
            ST_FIN:   c_out_load = out_free;
            default: ;
        endcase
    end

    assign s_axis_tready = c_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ring memory
    logic [LOAD_W-1:0] ram_wdata;
    logic [LOAD_W-1:0] ram_rdata;

    assign ram_wdata = LOAD_W'(r_tasks) * LOAD_W'(LOAD_SCALE);

    chlg_ram #(
        .WIDTH (LOAD_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (c_ram_we),
        .i_waddr (r_pos),
        .i_wdata (ram_wdata),
        .i_re    (c_ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    // window clamp
    logic [WIN_W-1:0] win_clamped;
    always_comb begin
        if (r_cfg_window == '0) begin
            win_clamped = WIN_W'(1);
        end else if (32'(r_cfg_window) > 32'(RING_DEPTH)) begin
            win_clamped = WIN_W'(RING_DEPTH);
        end else begin
            win_clamped = WIN_W'(r_cfg_window);
        end
    end

    // divider step: one quotient bit a cycle
    logic [WIN_W:0] rem_shift;
    logic           rem_ge;
    assign rem_shift = {r_rem, r_sum[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, r_win};

    // decision logic
    logic [LOAD_W:0]     avg_ext;
    logic [LOAD_W:0]     up_load;
    logic [LOAD_W:0]     down_load;
    logic [11:0]         delay_full;
    logic [DELAY_W-1:0]  delay_sat;
    logic                below_limit;
    logic [ACTION_W-1:0] dec_action;
    logic [DELAY_W-1:0]  dec_delay;
    logic                dec_paused;

    assign avg_ext     = {1'b0, r_sum[LOAD_W-1:0]};
    assign up_load     = (LOAD_W + 1)'(r_cfg_up) * (LOAD_W + 1)'(r_online);
    assign down_load   = (LOAD_W + 1)'(r_cfg_down) * (LOAD_W + 1)'(r_online);
    assign delay_full  = 12'(r_cfg_interval) * 12'(r_online);
    assign delay_sat   = (delay_full > 12'(DELAY_MAX)) ? DELAY_MAX : delay_full[DELAY_W-1:0];
    assign below_limit = r_online < r_cfg_limit;

    always_comb begin
        dec_action = ACT_NONE;
        dec_delay  = delay_sat;
        dec_paused = r_paused;
        if (!r_cfg_disabled) begin
            if (avg_ext >= (LOAD_W + 1)'(r_cfg_all) && below_limit) begin
                dec_action = ACT_ONLINE_ALL;
                dec_delay  = DELAY_W'(r_cfg_interval);
                dec_paused = 1'b1;
            end else if (r_paused) begin
                dec_action = ACT_HELD;
                dec_delay  = DELAY_W'(r_cfg_interval);
            end else if (avg_ext >= up_load && below_limit) begin
                dec_action = ACT_ONLINE_ONE;
                dec_delay  = DELAY_W'(r_cfg_interval);
            end else if (avg_ext <= down_load) begin
                dec_action = r_pending ? ACT_NONE : ACT_OFFLINE;
            end
        end
    end

    // control registers of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paused <= 1'b1;
            r_pos    <= '0;
            r_fill   <= '0;
            r_acc    <= 1'b0;
        end else begin
            r_acc <= c_ram_re;
            if (in_xfer && s_axis_tuser) begin
                r_paused <= 1'b0;
            end
            if (r_state == ST_DECIDE) begin
                r_paused <= dec_paused;
            end
            if (c_ram_we) begin
                r_pos <= (r_pos == ADDR_W'(RING_DEPTH - 1)) ? '0 : r_pos + ADDR_W'(1);
                if (r_fill != FILL_W'(RING_DEPTH)) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
        end
    end

    // payload registers of the datapath
    always_ff @(posedge i_clk) begin
        r_hit <= FILL_W'(r_rd_addr) < r_fill;
        if (in_xfer) begin
            r_tasks      <= s_axis_tdata[7:0];
            r_online     <= s_axis_tdata[10:8];
            r_pending    <= s_axis_tdata[11];
            // unpause result
            r_res_action <= ACT_NONE;
            r_res_avg    <= '0;
            r_res_delay  <= '0;
            r_res_paused <= 1'b0;
        end
        case (r_state)
            ST_WRITE: begin
                r_rd_addr <= r_pos;
                r_win     <= win_clamped;
                r_cnt     <= '0;
                r_sum     <= '0;
            end
            ST_READ, ST_DRAIN: begin
                if (r_acc && r_hit) begin
                    r_sum <= r_sum + SUM_W'(ram_rdata);
                end
                if (r_state == ST_READ) begin
                    r_cnt     <= r_cnt + WIN_W'(1);
                    r_rd_addr <= (r_rd_addr == '0) ? ADDR_W'(RING_DEPTH - 1)
                                                   : r_rd_addr - ADDR_W'(1);
                end else begin
                    r_rem     <= '0;
                    r_div_cnt <= DCNT_W'(SUM_W);
                end
            end
            ST_DIV: begin
                r_rem     <= rem_ge ? WIN_W'(rem_shift - {1'b0, r_win}) : rem_shift[WIN_W-1:0];
                r_sum     <= {r_sum[SUM_W-2:0], rem_ge};
                r_div_cnt <= r_div_cnt - DCNT_W'(1);
            end
            ST_DECIDE: begin
                r_res_action <= dec_action;
                r_res_avg    <= r_sum[LOAD_W-1:0];
                r_res_delay  <= dec_delay;
                r_res_paused <= dec_paused;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_out_load) begin
            r_out_data <= M_TDATA_W'({r_res_paused, r_res_delay, r_res_avg, r_res_action});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(RING_DEPTH))
        else $error("ring fill count beyond depth");

    a_sample_to_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !s_axis_tuser) |=> (r_state == ST_WRITE))
        else $error("sample transfer did not start a ring write");

    a_walk_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_cnt < r_win))
        else $error("ring walk ran past the window");

    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> ((r_sum >> LOAD_W) == '0))
        else $error("average does not fit the load width");

    a_all_sets_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] == ACT_ONLINE_ALL) |-> m_axis_tdata[29])
        else $error("online all result without pause flag");

endmodule

/* hw/rtl/chlg_ram.sv */
// generic single write port ram with registered read
module chlg_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* test/chlg_governor_checker.sv */
// result checker of the hotplug load governor: mirrors the governor and compares every result
`timescale 1ns / 1ps

module chlg_governor_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [chlg_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [chlg_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                           i_cfg_we,
    input  logic [chlg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [chlg_pkg::CFG_W-1:0]     i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_outstanding,
    output int                             o_checked
);
    import chlg_pkg::*;

    localparam int DEPTH    = RING_DEPTH_DEF;
    localparam int AVG_LSB  = ACTION_W;
    localparam int DLY_LSB  = ACTION_W + LOAD_W;
    localparam int PAUSE_B  = ACTION_W + LOAD_W + DELAY_W;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LOAD_W-1:0]   avg_load;
        logic [DELAY_W-1:0]  delay_ms;
        logic                paused;
    } t_decision;

    // mirrored register file
    logic [9:0] thr_all;
    logic [8:0] thr_up;
    logic [7:0] thr_down;
    logic [2:0] max_cores;
    logic [5:0] avg_window;
    logic [8:0] interval_ms;
    logic       gov_off;

    // mirrored governor state
    logic [LOAD_W-1:0] load_hist [DEPTH];
    int unsigned       hist_ptr;
    logic              pause_flag;

    t_decision expected_decisions[$];
    int        fail_total    = 0;
    int        checked_total = 0;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;

    task automatic report_mismatch(string msg);
        fail_total++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // one item through the governor, state updated as it goes
    function automatic t_decision predict_decision(logic cmd, logic [TASK_W-1:0] tasks,
            logic [CORES_W-1:0] cores, logic pend);
        t_decision   r;
        int unsigned win, sum, idx, avg, dly, up_load, down_load, n;
        r = '0;
        if (cmd) begin
            // unpause leaves the ring alone and reports all zero
            pause_flag = 1'b0;
            return r;
        end
        load_hist[hist_ptr] = LOAD_W'(int'(tasks) * int'(LOAD_SCALE));
        win = avg_window;
        if (win == 0) win = 1;
        if (win > DEPTH) win = DEPTH;
        sum = 0;
        idx = hist_ptr;
        for (n = 0; n < win; n++) begin
            sum += load_hist[idx];
            idx = (idx == 0) ? DEPTH - 1 : idx - 1;
        end
        avg      = sum / win;
        hist_ptr = (hist_ptr + 1) % DEPTH;

        dly = interval_ms * cores;
        if (dly > DELAY_MAX) dly = DELAY_MAX;
        r.action = ACT_NONE;
        if (!gov_off) begin
            up_load   = thr_up * cores;
            down_load = thr_down * cores;
            if (avg >= thr_all && cores < max_cores) begin
                pause_flag = 1'b1;
                r.action   = ACT_ONLINE_ALL;
                dly        = interval_ms;
            end else if (pause_flag) begin
                r.action = ACT_HELD;
                dly      = interval_ms;
            end else if (avg >= up_load && cores < max_cores) begin
                r.action = ACT_ONLINE_ONE;
                dly      = interval_ms;
            end else if (avg <= down_load) begin
                r.action = pend ? ACT_NONE : ACT_OFFLINE;
            end
        end
        r.avg_load = LOAD_W'(avg);
        r.delay_ms = DELAY_W'(dly);
        r.paused   = pause_flag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_decision got, want;
        if (!i_rst_n) begin
            thr_all     = RST_ALL_THR;
            thr_up      = RST_UP_THR;
            thr_down    = RST_DOWN_THR;
            max_cores   = RST_LIMIT;
            avg_window  = RST_WINDOW;
            interval_ms = RST_INTERVAL;
            gov_off     = 1'b0;
            foreach (load_hist[k]) load_hist[k] = '0;
            hist_ptr   = 0;
            pause_flag = 1'b1;
            expected_decisions.delete();
        end else begin
            // results first: a result at this edge belongs to an earlier item
            if (i_m_tvalid && i_m_tready) begin
                got.action   = i_m_tdata[ACTION_W-1:0];
                got.avg_load = i_m_tdata[AVG_LSB +: LOAD_W];
                got.delay_ms = i_m_tdata[DLY_LSB +: DELAY_W];
                got.paused   = i_m_tdata[PAUSE_B];
                if (expected_decisions.size() == 0) begin
                    report_mismatch($sformatf("result 0x%08h with no item waiting", i_m_tdata));
                end else begin
                    want = expected_decisions.pop_front();
                    if (got.action !== want.action)
                        report_mismatch($sformatf("result %0d action %0d, expected %0d",
                            checked_total, got.action, want.action));
                    if (got.avg_load !== want.avg_load)
                        report_mismatch($sformatf("result %0d average_load %0d, expected %0d",
                            checked_total, got.avg_load, want.avg_load));
                    if (got.delay_ms !== want.delay_ms)
                        report_mismatch($sformatf("result %0d next_delay_ms %0d, expected %0d",
                            checked_total, got.delay_ms, want.delay_ms));
                    if (got.paused !== want.paused)
                        report_mismatch($sformatf("result %0d paused_now %0b, expected %0b",
                            checked_total, got.paused, want.paused));
                    if (i_m_tdata[M_TDATA_W-1:PAUSE_B+1] !== '0)
                        report_mismatch($sformatf("result %0d padding bits not zero: 0x%08h",
                            checked_total, i_m_tdata));
                    checked_total++;
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ALL_THR:  thr_all     = i_cfg_wdata[9:0];
                    REG_UP_THR:   thr_up      = i_cfg_wdata[8:0];
                    REG_DOWN_THR: thr_down    = i_cfg_wdata[7:0];
                    REG_LIMIT:    max_cores   = i_cfg_wdata[2:0];
                    REG_WINDOW:   avg_window  = i_cfg_wdata[5:0];
                    REG_INTERVAL: interval_ms = i_cfg_wdata[8:0];
                    REG_DISABLE:  gov_off     = i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                expected_decisions.push_back(predict_decision(i_s_tuser,
                    i_s_tdata[TASK_W-1:0], i_s_tdata[TASK_W +: CORES_W],
                    i_s_tdata[TASK_W+CORES_W]));
            end
        end
        o_outstanding <= expected_decisions.size();
    end

endmodule

/* test/tb_top.sv */
// testbench top of the hotplug load governor: stimulus, stream idling and the verdict
`timescale 1ns / 1ps

module tb_top;
    import chlg_pkg::*;

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int HOLDOFF_CYCLES  = 400;
    // covers the tail of the last sample, also at the widest window
    localparam int SETTLE_CYCLES   = 80;
    // slowest correct run is ~1200 items plus pauses; the limit is several times over
    localparam int CYCLE_LIMIT     = 600_000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [7:0] runnable_tasks, [10:8] cores_online, [11] offline_pending, rest zero
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    // [0] command
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [2:0] action, [17:3] average_load, [28:18] next_delay_ms, [29] paused_now
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_wdata;

    int fail_count;
    int outstanding;
    int checked;

    // handshakes between the stimulus and the receiver process
    bit hold_off_req = 1'b0;
    bit quiet_tail   = 1'b0;

    int unsigned cycle_count      = 0;
    int unsigned items_sent       = 0;
    int unsigned samples_sent     = 0;
    int unsigned unpauses_sent    = 0;
    int unsigned settings_applied = 0;

    cpu_hotplug_load_governor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // watches both streams and the register port, predicts and compares
    chlg_governor_checker result_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    // result side: random stall and run bursts, a long hold-off on request,
    // and always ready once the quiet tail starts
    initial begin
        int unsigned span;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                span = $urandom_range(1, 13);
                repeat (span) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                span = quiet_tail ? 1 : $urandom_range(1, 40);
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // one input transfer; returns at the edge that accepted it, valid still high
    task automatic send_item(logic cmd, logic [TASK_W-1:0] tasks,
            logic [CORES_W-1:0] cores, logic pend);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= S_TDATA_W'({pend, cores, tasks});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (cmd) unpauses_sent++;
        else samples_sent++;
    endtask

    // sender gap with junk on the data lines
    task automatic idle_sender(int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= S_TDATA_W'($urandom);
        s_axis_tuser  <= 1'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    // hold the sender until every result is back and the block has gone idle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register write; unused upper data bits carry junk
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val,
            int unsigned width);
        logic [CFG_W-1:0] keep;
        keep        = CFG_W'((1 << width) - 1);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= (CFG_W'($urandom) & ~keep) | (val & keep);
        @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [9:0] all_thr, logic [8:0] up_thr,
            logic [7:0] down_thr, logic [2:0] limit, logic [5:0] window,
            logic [8:0] interval, logic gov_off);
        write_reg(REG_ALL_THR, CFG_W'(all_thr), 10);
        write_reg(REG_UP_THR, CFG_W'(up_thr), 9);
        write_reg(REG_DOWN_THR, CFG_W'(down_thr), 8);
        write_reg(REG_LIMIT, CFG_W'(limit), 3);
        write_reg(REG_WINDOW, CFG_W'(window), 6);
        write_reg(REG_INTERVAL, CFG_W'(interval), 9);
        write_reg(REG_DISABLE, CFG_W'(gov_off), 1);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    initial begin
        int unsigned phase, n, level, gap_mode, unpause_odds, burst_left;
        int          tasks_val;
        logic [5:0]  window;
        logic [2:0]  cores;
        logic        cmd;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_ALL_THR;
        i_cfg_wdata   = '0;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset settings: the block boots paused
        send_item(1'b0, 8'd0, 3'd1, 1'b0);      // held while paused
        send_item(1'b1, 8'd255, 3'd7, 1'b1);    // unpause with every data bit set
        send_item(1'b0, 8'd0, 3'd1, 1'b0);      // idle load, one core goes down
        send_item(1'b0, 8'd0, 3'd1, 1'b1);      // same, offline already pending
        send_item(1'b0, 8'd255, 3'd1, 1'b0);    // heavy load, all cores up and pause
        send_item(1'b0, 8'd255, 3'd2, 1'b0);    // still heavy and below limit, all cores up again despite the pause
        send_item(1'b1, 8'd0, 3'd0, 1'b0);
        send_item(1'b0, 8'd255, 3'd4, 1'b1);    // at the core limit, nothing to do

        // directed, window of zero (used as one) and an interval of 500
        wait_drained();
        apply_settings(RST_ALL_THR, RST_UP_THR, RST_DOWN_THR, RST_LIMIT, 6'd0, 9'd500, 1'b0);
        send_item(1'b0, 8'd3, 3'd1, 1'b0);      // one more core
        send_item(1'b0, 8'd4, 3'd2, 1'b0);      // between the thresholds
        send_item(1'b0, 8'd2, 3'd2, 1'b0);      // exactly on the down threshold
        send_item(1'b0, 8'd0, 3'd0, 1'b0);      // zero cores online
        send_item(1'b0, 8'd255, 3'd5, 1'b0);    // delay saturates
        send_item(1'b0, 8'd255, 3'd7, 1'b1);
        send_item(1'b0, 8'd6, 3'd3, 1'b0);      // all cores up, pause again
        send_item(1'b1, 8'd0, 3'd1, 1'b0);
        send_item(1'b0, 8'd1, 3'd1, 1'b1);

        // directed, governor switched off: sampling only
        wait_drained();
        apply_settings(RST_ALL_THR, RST_UP_THR, RST_DOWN_THR, RST_LIMIT, 6'd0, 9'd500, 1'b1);
        send_item(1'b0, 8'd255, 3'd4, 1'b0);
        send_item(1'b0, 8'd0, 3'd6, 1'b0);
        send_item(1'b0, 8'd0, 3'd1, 1'b0);

        // random phases, each with its own register setting
        level        = 3;
        gap_mode     = 1;
        unpause_odds = 10;
        burst_left   = 0;
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            window = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(1, 32));
            case (phase)
                0: apply_settings(10'd0, 9'd0, 8'd0, 3'd1, 6'd1, 9'd1, 1'b0);
                1: apply_settings(10'd600, 9'd500, 8'd200, 3'd4, 6'd32, 9'd500, 1'b0);
                2: apply_settings(10'($urandom_range(0, 600)), 9'($urandom_range(0, 500)),
                       8'($urandom_range(0, 200)), 3'($urandom_range(1, 4)), 6'd63,
                       9'($urandom_range(1, 500)), 1'b0);
                default: apply_settings(10'($urandom_range(0, 600)),
                       9'($urandom_range(0, 500)), 8'($urandom_range(0, 200)),
                       3'($urandom_range(1, 4)), window, 9'($urandom_range(1, 500)),
                       1'($urandom_range(0, 5) == 0));
            endcase
            quiet_tail = (phase == PHASES - 1);

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // receiver holds off while the sender keeps offering items back to back
                if (phase == 3 && n == 20) begin
                    hold_off_req = 1'b1;
                    burst_left   = 20;
                end
                // sender stops until every result is back
                if (phase == 5 && n == 60) wait_drained();

                // new load level and idling character every so often
                if (n % 25 == 0) begin
                    level        = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 12);
                    gap_mode     = $urandom_range(0, 2);
                    unpause_odds = ($urandom_range(0, 1) == 0) ? 6 : 20;
                end

                cmd = ($urandom_range(1, unpause_odds) == 1);
                if ($urandom_range(0, 15) == 0) begin
                    tasks_val = $urandom_range(0, 255);
                end else begin
                    tasks_val = int'(level) + int'($urandom_range(0, 4)) - 2;
                    if (tasks_val < 0) tasks_val = 0;
                    if (tasks_val > 255) tasks_val = 255;
                end
                cores = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7))
                                                     : 3'($urandom_range(1, 4));
                send_item(cmd, TASK_W'(tasks_val), cores, 1'($urandom_range(0, 1)));

                if (burst_left != 0) begin
                    burst_left--;
                end else if (!quiet_tail && gap_mode != 0 &&
                             $urandom_range(0, gap_mode == 1 ? 3 : 1) == 0) begin
                    idle_sender($urandom_range(1, 13));
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d items (%0d samples, %0d unpause) over %0d register settings",
                 items_sent, samples_sent, unpauses_sent, settings_applied);
        $display("%0d results compared in %0d cycles, with result hold-off and sender drain",
                 checked, cycle_count);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
